FILE: rtl/core/imsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imsu_pkg;

    // lattice geometry
    localparam int SIDE  = 64;
    localparam int RW    = $clog2(SIDE);
    localparam int CELLS = SIDE * SIDE;

    // full-precision widths of the running totals
    localparam int EW = $clog2(2 * CELLS) + 2;
    localparam int MW = $clog2(CELLS) + 2;

    localparam logic signed [EW-1:0] ENERGY_INIT = EW'(-2 * CELLS);
    localparam logic signed [MW-1:0] MAG_INIT    = MW'(CELLS);

    // item kinds
    localparam logic FUNC_ATTEMPT = 1'b0;
    localparam logic FUNC_SET     = 1'b1;

    // register select, paddr bit 3 picks the 64-bit word
    localparam logic CFG_THR_DE4 = 1'b0;
    localparam logic CFG_THR_DE8 = 1'b1;

    typedef logic [RW-1:0]   idx_t;
    typedef logic [SIDE-1:0] row_t;

    // the three lattice rows an update needs
    typedef struct packed {
        row_t centre;
        row_t above;
        row_t below;
    } rows_t;

    typedef struct packed {
        logic              flip;
        logic signed [4:0] de;
        logic              spin_up;
    } decision_t;

    // input index reduced modulo SIDE (small constant table)
    function automatic idx_t wrap_in(input logic [5:0] v);
        idx_t res;
        res = '0;
        for (int k = 0; k < 64; k++) begin
            if (v == 6'(k)) begin
                res = RW'(k % SIDE);
            end
        end
        return res;
    endfunction

    function automatic idx_t next_idx(input idx_t i);
        return (i == RW'(SIDE - 1)) ? '0 : i + RW'(1);
    endfunction

    function automatic idx_t prev_idx(input idx_t i);
        return (i == '0) ? RW'(SIDE - 1) : i - RW'(1);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/imsu_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module imsu_cfg_regs
    import imsu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    output logic      [32:0] thr_de4,
    output logic      [32:0] thr_de8
);

    logic [32:0] thr_de4_reg, thr_de4_next;
    logic [32:0] thr_de8_reg, thr_de8_next;
    logic        wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready;

    always_comb begin
        thr_de4_next = thr_de4_reg;
        thr_de8_next = thr_de8_reg;
        if (wr_hit) begin
            unique case (paddr[3])
                CFG_THR_DE4: thr_de4_next = pwdata[32:0];
                CFG_THR_DE8: thr_de8_next = pwdata[32:0];
                default:     thr_de4_next = thr_de4_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_de4_reg <= '0;
            thr_de8_reg <= '0;
        end else begin
            thr_de4_reg <= thr_de4_next;
            thr_de8_reg <= thr_de8_next;
        end
    end

    always_comb begin
        unique case (paddr[3])
            CFG_THR_DE4: prdata = {31'd0, thr_de4_reg};
            CFG_THR_DE8: prdata = {31'd0, thr_de8_reg};
            default:     prdata = '0;
        endcase
    end

    assign thr_de4 = thr_de4_reg;
    assign thr_de8 = thr_de8_reg;

endmodule

`default_nettype wire

FILE: rtl/core/imsu_lattice_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module imsu_lattice_mem
    import imsu_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  rd_en,
    input  wire idx_t  rd_centre,
    input  wire idx_t  rd_above,
    input  wire idx_t  rd_below,
    input  wire logic  wr_en,
    input  wire idx_t  wr_addr,
    input  wire row_t  wr_data,
    output rows_t      rows,
    output logic       clearing
);

    // two copies: one serves the centre row, the other both neighbour rows
    row_t mem_a [SIDE];
    row_t mem_b [SIDE];

    row_t q_centre, q_above, q_below;
    row_t fwd_row_reg;
    logic hit_c_reg, hit_a_reg, hit_b_reg;

    logic clr_busy_reg, clr_busy_next;
    idx_t clr_addr_reg, clr_addr_next;

    logic we;
    idx_t wa;
    row_t wd;

    // sweep every row to all-up after reset
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = next_idx(clr_addr_reg);
            if (clr_addr_reg == RW'(SIDE - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign we = clr_busy_reg || wr_en;
    assign wa = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign wd = clr_busy_reg ? '1 : wr_data;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_a[wa] <= wd;
        end
        if (rd_en) begin
            q_centre <= mem_a[rd_centre];
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_b[wa] <= wd;
        end
        if (rd_en) begin
            q_above <= mem_b[rd_above];
            q_below <= mem_b[rd_below];
        end
    end

    // a row written on the same edge as the read comes from the bypass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_c_reg <= 1'b0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end else if (rd_en) begin
            hit_c_reg <= wr_en && (wr_addr == rd_centre);
            hit_a_reg <= wr_en && (wr_addr == rd_above);
            hit_b_reg <= wr_en && (wr_addr == rd_below);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_row_reg <= wr_data;
        end
    end

    assign rows.centre = hit_c_reg ? fwd_row_reg : q_centre;
    assign rows.above  = hit_a_reg ? fwd_row_reg : q_above;
    assign rows.below  = hit_b_reg ? fwd_row_reg : q_below;
    assign clearing    = clr_busy_reg;

endmodule

`default_nettype wire

FILE: rtl/core/imsu_site_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module imsu_site_eval
    import imsu_pkg::*;
(
    input  wire rows_t        rows,
    input  wire idx_t         col,
    input  wire logic         func,
    input  wire logic [31:0]  random_fraction,
    input  wire logic         new_spin,
    input  wire logic [32:0]  thr_de4,
    input  wire logic [32:0]  thr_de8,
    output decision_t         dec
);

    idx_t              col_p, col_m;
    logic              spin_up;
    logic [2:0]        ups;
    logic signed [4:0] de_up;
    logic signed [4:0] de;
    logic              take;

    assign col_p   = next_idx(col);
    assign col_m   = prev_idx(col);
    assign spin_up = rows.centre[col];

    // number of up neighbours, 0..4
    assign ups = 3'(rows.centre[col_p]) + 3'(rows.centre[col_m])
               + 3'(rows.above[col]) + 3'(rows.below[col]);

    // dE for an up spin; a down spin has the opposite sign
    always_comb begin
        case (ups)
            3'd0:    de_up = -5'sd8;
            3'd1:    de_up = -5'sd4;
            3'd2:    de_up = 5'sd0;
            3'd3:    de_up = 5'sd4;
            3'd4:    de_up = 5'sd8;
            default: de_up = 5'sd0;
        endcase
    end

    assign de = spin_up ? de_up : -de_up;

    always_comb begin
        if (func == FUNC_SET) begin
            take = (spin_up != new_spin);
        end else if (de <= 5'sd0) begin
            take = 1'b1;
        end else if (de == 5'sd4) begin
            take = {1'b0, random_fraction} < thr_de4;
        end else begin
            take = {1'b0, random_fraction} < thr_de8;
        end
    end

    assign dec.flip    = take;
    assign dec.de      = de;
    assign dec.spin_up = spin_up;

endmodule

`default_nettype wire

FILE: rtl/core/ising_metropolis_spin_update.sv
`timescale 1ns / 1ps
`default_nettype none

// Metropolis spin update for a periodic SIDE x SIDE Ising lattice (SIDE = 64).
// Each input transfer names a site: func 0 is a flip attempt judged against the
// two acceptance thresholds, func 1 loads new_spin into the site. Every item
// gives exactly one result transfer with the flip flag, the site's dE and the
// running energy, magnetisation and saturating accepted-flip count. The block
// takes one item per cycle while the result channel is not stalled: the
// lattice is held as rows in two copies of a row-wide memory, the centre row
// read from one copy and the rows above and below from the other, and a row
// written back on the same edge as the next read is forwarded. After reset
// the lattice is swept to all spins up, one row a cycle, with s_ready low
// until the sweep ends; the APB port takes writes throughout. Thresholds sit
// at byte addresses 0x0 (dE 4) and 0x8 (dE 8), 33 bits each on a 64-bit bus.

module ising_metropolis_spin_update
    import imsu_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic      [63:0]        prdata,
    output logic                    pready,
    // input channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_func,
    input  wire logic [5:0]         s_row_index,
    input  wire logic [5:0]         s_col_index,
    input  wire logic [31:0]        s_random_fraction,
    input  wire logic               s_new_spin,
    // result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_flipped,
    output logic signed [4:0]       m_energy_change,
    output logic signed [14:0]      m_lattice_energy,
    output logic signed [13:0]      m_lattice_magnetization,
    output logic [31:0]             m_flip_total
);

    logic [32:0] thr_de4, thr_de8;

    imsu_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .thr_de4 (thr_de4),
        .thr_de8 (thr_de8)
    );

    // ---- input side: reduce the indices and issue the row reads ----
    logic s_accept;
    idx_t row_in, col_in;
    idx_t row_above, row_below;

    assign s_accept  = s_valid && s_ready;
    assign row_in    = wrap_in(s_row_index);
    assign col_in    = wrap_in(s_col_index);
    assign row_above = prev_idx(row_in);
    assign row_below = next_idx(row_in);

    // ---- evaluation stage: item register, rows arrive from memory ----
    logic        v1_reg, v1_next;
    logic        func_reg;
    idx_t        row_reg, col_reg;
    logic [31:0] frac_reg;
    logic        spin_req_reg;
    logic        adv;

    rows_t     rows;
    decision_t dec;
    logic      clearing;
    logic      wr_en;
    row_t      wr_data;

    imsu_lattice_mem u_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_accept),
        .rd_centre (row_in),
        .rd_above  (row_above),
        .rd_below  (row_below),
        .wr_en     (wr_en),
        .wr_addr   (row_reg),
        .wr_data   (wr_data),
        .rows      (rows),
        .clearing  (clearing)
    );

    imsu_site_eval u_eval (
        .rows            (rows),
        .col             (col_reg),
        .func            (func_reg),
        .random_fraction (frac_reg),
        .new_spin        (spin_req_reg),
        .thr_de4         (thr_de4),
        .thr_de8         (thr_de8),
        .dec             (dec)
    );

    // the evaluated item moves on when the result register is free
    assign adv     = v1_reg && (!m_valid || m_ready);
    assign s_ready = !clearing && (!v1_reg || adv);

    // write back the centre row with the site inverted
    assign wr_en   = adv && dec.flip;
    assign wr_data = rows.centre ^ (row_t'(1) << col_reg);

    always_comb begin
        v1_next = v1_reg;
        if (s_accept) begin
            v1_next = 1'b1;
        end else if (adv) begin
            v1_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg     <= s_func;
            row_reg      <= row_in;
            col_reg      <= col_in;
            frac_reg     <= s_random_fraction;
            spin_req_reg <= s_new_spin;
        end
    end

    // ---- running totals ----
    logic signed [EW-1:0] energy_reg, energy_next;
    logic signed [MW-1:0] mag_reg, mag_next;
    logic [31:0]          count_reg, count_next;
    logic signed [31:0]   energy_wide, mag_wide;

    always_comb begin
        energy_next = energy_reg;
        mag_next    = mag_reg;
        count_next  = count_reg;
        if (dec.flip) begin
            energy_next = energy_reg + EW'(dec.de);
            // an up spin going down loses two, a down spin going up gains two
            mag_next    = dec.spin_up ? mag_reg - MW'(2) : mag_reg + MW'(2);
            if (func_reg == FUNC_ATTEMPT && count_reg != '1) begin
                count_next = count_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg <= ENERGY_INIT;
            mag_reg    <= MAG_INIT;
            count_reg  <= '0;
        end else if (adv) begin
            energy_reg <= energy_next;
            mag_reg    <= mag_next;
            count_reg  <= count_next;
        end
    end

    // outputs carry the low bits, sign-extended first for small lattices
    assign energy_wide = 32'(energy_next);
    assign mag_wide    = 32'(mag_next);

    // ---- result register ----
    logic m_valid_reg, m_valid_next;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_flipped               <= dec.flip;
            m_energy_change         <= dec.de;
            m_lattice_energy        <= energy_wide[14:0];
            m_lattice_magnetization <= mag_wide[13:0];
            m_flip_total            <= count_next;
        end
    end

    assign m_valid = m_valid_reg;

    // ---- checks ----

    // no transfer is taken while the lattice sweep is still running
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !clearing)
        else $error("input transfer during lattice clear");

    // an accepted attempt below saturation bumps the count by one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && dec.flip && func_reg == FUNC_ATTEMPT && count_reg != '1
        |=> count_reg == $past(count_reg) + 32'd1)
        else $error("accepted flip count did not advance");

    // an item that does not flip leaves the totals alone
    a_totals_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !dec.flip |=> energy_reg == $past(energy_reg) && mag_reg == $past(mag_reg))
        else $error("totals moved without a flip");

    // dE is always one of the five lattice values
    a_de_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_energy_change == -5'sd8 || m_energy_change == -5'sd4 ||
                         m_energy_change == 5'sd0 || m_energy_change == 5'sd4 ||
                         m_energy_change == 5'sd8))
        else $error("illegal energy change");

endmodule

`default_nettype wire
